// ----- hw/rtl/leb_pkg.sv -----
// Shared types and constants for the line-edit buffer.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package leb_pkg;

  // Input command codes
  localparam logic [2:0] CMD_KEY     = 3'd0;
  localparam logic [2:0] CMD_FWD     = 3'd1;
  localparam logic [2:0] CMD_BACK    = 3'd2;
  localparam logic [2:0] CMD_SET     = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;
  localparam logic [2:0] CMD_DISCARD = 3'd5;
  localparam logic [2:0] CMD_WRITE   = 3'd6;

  // Key byte classes
  localparam logic [7:0] KEY_BACKSPACE = 8'h08;
  localparam logic [7:0] KEY_PRINT_LO  = 8'h20;
  localparam logic [7:0] KEY_PRINT_HI  = 8'h7E;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NONE = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // Classified operation handed from the front to the back
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE,
    OP_FWD,
    OP_BACK,
    OP_SET,
    OP_READ,
    OP_DISCARD,
    OP_WRITE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] key;
    logic [8:0] pos;
  } req_t;

  // Handshake between the request queue and the back end
  typedef struct packed {
    logic valid;
    req_t req;
  } req_chan_t;

endpackage

`default_nettype wire

// ----- hw/rtl/line_edit_buffer_core.sv -----
// Line-edit buffer top level: front classifier, request queue, back end.
// Depends on leb_pkg, leb_front, leb_req_fifo and leb_back.
//
// Usage:
//   Requests enter as a queue: drive command, key_byte and position_index
//   with push; a request is taken at a clock edge with push high, full low.
//   Results leave as a queue: while empty is low the oldest result sits on
//   status, read_char, line_length and cursor_index; pop takes it.
//   Cursor moves, set, overwrite and ignored keys load the result register
//   as soon as they are taken; a read first passes through the store's read
//   register and the S_READ state. Insert, backspace and discard move the
//   tail of the line through the store's single write port at one character
//   per cycle before their result is loaded. The back end starts a request
//   only once the previous result has been popped; a two-entry queue keeps
//   the input side open while a result waits. A stalled receiver simply
//   holds the result.
//   Reset (rst, synchronous) empties both queues and clears length and
//   cursor; the character store is not cleared and needs no sweep.
`default_nettype none

module line_edit_buffer_core #(
  parameter int CAPACITY = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [2:0] command,
  input  wire logic [7:0] key_byte,
  input  wire logic [8:0] position_index,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      status,
  output logic [7:0]      read_char,
  output logic [8:0]      line_length,
  output logic [8:0]      cursor_index
);
  import leb_pkg::*;

  req_t      front_req;
  req_chan_t head;
  logic      take;

  // Classify incoming requests
  leb_front u_front (
    .command        (command),
    .key_byte       (key_byte),
    .position_index (position_index),
    .req            (front_req)
  );

  // Decouple front and back
  leb_req_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (front_req),
    .full     (full),
    .take     (take),
    .head     (head)
  );

  // Execute against the line store
  leb_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .take         (take),
    .empty        (empty),
    .pop          (pop),
    .status       (status),
    .read_char    (read_char),
    .line_length  (line_length),
    .cursor_index (cursor_index)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/leb_front.sv -----
// Front end of the line-edit buffer: classifies each incoming request.
// Depends on leb_pkg; feeds leb_req_fifo.
`default_nettype none

module leb_front (
  input  wire logic [2:0]   command,
  input  wire logic [7:0]   key_byte,
  input  wire logic [8:0]   position_index,
  output leb_pkg::req_t     req
);
  import leb_pkg::*;

  // Classify the command and, for key bytes, the byte itself
  always_comb begin
    req.key = key_byte;
    req.pos = position_index;
    case (command)
      CMD_KEY: begin
        if (key_byte == KEY_BACKSPACE) begin
          req.op = OP_DELETE;
        end else if (key_byte >= KEY_PRINT_LO && key_byte <= KEY_PRINT_HI) begin
          req.op = OP_INSERT;
        end else begin
          req.op = OP_NONE;
        end
      end
      CMD_FWD:     req.op = OP_FWD;
      CMD_BACK:    req.op = OP_BACK;
      CMD_SET:     req.op = OP_SET;
      CMD_READ:    req.op = OP_READ;
      CMD_DISCARD: req.op = OP_DISCARD;
      CMD_WRITE:   req.op = OP_WRITE;
      default:     req.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/leb_req_fifo.sv -----
// Two-entry request queue between the front and back ends.
// Depends on leb_pkg.
`default_nettype none

module leb_req_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire leb_pkg::req_t  push_req,
  output logic                full,
  input  wire logic           take,
  output leb_pkg::req_chan_t  head
);
  import leb_pkg::*;

  req_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_take;

  assign full    = (count == 2'd2);
  assign do_push = push && !full;
  assign do_take = take && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.req   = entries[rd_ptr];

  // Hold request payloads
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/leb_back.sv -----
// Back end of the line-edit buffer: character store, length, cursor and
// the shift sequencer, plus the result register. Depends on leb_pkg.
`default_nettype none

module leb_back #(
  parameter int CAPACITY = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire leb_pkg::req_chan_t head,
  output logic                    take,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              status,
  output logic [7:0]              read_char,
  output logic [8:0]              line_length,
  output logic [8:0]              cursor_index
);
  import leb_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > 9) ? LW : 9;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t          state;
  logic [LW-1:0]   len;
  logic [LW-1:0]   tail_dist;
  logic            res_valid;
  status_t         res_status;
  logic [7:0]      res_char;

  // Shift sequencer
  logic            dir_right;
  logic [LW-1:0]   iss;
  logic [LW-1:0]   lim;
  logic [LW-1:0]   gap;
  logic [7:0]      key_r;
  logic            pend;
  logic [LW-1:0]   pend_dst;

  // Character store
  logic [7:0]      mem [CAPACITY];
  logic [7:0]      rdata;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [7:0]      mem_wdata;
  logic [AW-1:0]   mem_raddr;

  logic [LW-1:0]   at;
  logic [CW-1:0]   pos_w;
  logic [CW-1:0]   len_w;
  logic [LW-1:0]   pos_l;
  logic            issue_ok;
  logic [LW-1:0]   src;
  logic [LW-1:0]   len_after;
  logic            shift_end;

  assign at        = len - tail_dist;
  assign pos_w     = CW'(head.req.pos);
  assign len_w     = CW'(len);
  assign pos_l     = LW'(pos_w);
  assign take      = (state == S_IDLE) && head.valid && !res_valid;
  assign issue_ok  = dir_right ? (iss > lim) : (iss < lim);
  assign src       = dir_right ? (iss - LW'(1)) : (iss + gap);
  assign len_after = len - gap;
  assign shift_end = (state == S_SHIFT) && !issue_ok && !pend;

  assign empty        = !res_valid;
  assign status       = res_status;
  assign read_char    = res_char;
  assign line_length  = 9'(len);
  assign cursor_index = 9'(at);

  // Select the store's write and read port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_l[AW-1:0];
    mem_wdata = head.req.key;
    if (state == S_SHIFT && pend) begin
      mem_we    = 1'b1;
      mem_waddr = pend_dst[AW-1:0];
      mem_wdata = rdata;
    end else if (shift_end && dir_right) begin
      mem_we    = 1'b1;
      mem_waddr = lim[AW-1:0];
      mem_wdata = key_r;
    end else if (take && head.req.op == OP_WRITE && pos_w < len_w) begin
      mem_we = 1'b1;
    end
    mem_raddr = (state == S_SHIFT) ? src[AW-1:0] : pos_l[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Hold sequencer payload
  always_ff @(posedge clk) begin
    if (take) begin
      key_r <= head.req.key;
      case (head.req.op)
        OP_DELETE: begin
          dir_right <= 1'b0;
          iss       <= at - LW'(1);
          lim       <= len - LW'(1);
          gap       <= LW'(1);
        end
        OP_INSERT: begin
          dir_right <= 1'b1;
          iss       <= len;
          lim       <= at;
          gap       <= LW'(1);
        end
        OP_DISCARD: begin
          dir_right <= 1'b0;
          iss       <= '0;
          lim       <= len - pos_l;
          gap       <= pos_l;
        end
        default: begin
          dir_right <= dir_right;
        end
      endcase
    end else if (state == S_SHIFT && issue_ok) begin
      iss <= dir_right ? (iss - LW'(1)) : (iss + LW'(1));
    end
    pend_dst <= iss;
  end

  // Execute requests and hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      tail_dist <= '0;
      res_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      pend <= (state == S_SHIFT) && issue_ok;
      case (state)
        S_IDLE: begin
          if (take) begin
            res_char  <= 8'd0;
            res_valid <= 1'b1;
            case (head.req.op)
              OP_FWD: begin
                if (tail_dist == '0) begin
                  res_status <= ST_NONE;
                end else begin
                  tail_dist  <= tail_dist - LW'(1);
                  res_status <= ST_DONE;
                end
              end
              OP_BACK: begin
                if (tail_dist >= len) begin
                  res_status <= ST_NONE;
                end else begin
                  tail_dist  <= tail_dist + LW'(1);
                  res_status <= ST_DONE;
                end
              end
              OP_SET: begin
                if (pos_w > len_w) begin
                  res_status <= ST_BAD;
                end else begin
                  tail_dist  <= len - pos_l;
                  res_status <= ST_DONE;
                end
              end
              OP_READ: begin
                if (pos_w >= len_w) begin
                  res_status <= ST_BAD;
                end else begin
                  res_valid <= 1'b0;
                  state     <= S_READ;
                end
              end
              OP_WRITE: begin
                res_status <= (pos_w >= len_w) ? ST_BAD : ST_DONE;
              end
              OP_DELETE: begin
                if (at == '0) begin
                  res_status <= ST_NONE;
                end else begin
                  res_valid <= 1'b0;
                  state     <= S_SHIFT;
                end
              end
              OP_INSERT: begin
                if (len == LW'(CAPACITY)) begin
                  res_status <= ST_BAD;
                end else begin
                  res_valid <= 1'b0;
                  state     <= S_SHIFT;
                end
              end
              OP_DISCARD: begin
                if (pos_w > len_w) begin
                  res_status <= ST_BAD;
                end else begin
                  res_valid <= 1'b0;
                  state     <= S_SHIFT;
                end
              end
              default: begin
                res_status <= ST_NONE;
              end
            endcase
          end
        end
        S_READ: begin
          res_char   <= rdata;
          res_status <= ST_DONE;
          res_valid  <= 1'b1;
          state      <= S_IDLE;
        end
        S_SHIFT: begin
          if (shift_end) begin
            if (dir_right) begin
              len <= len + LW'(1);
            end else begin
              len <= len_after;
              if (tail_dist > len_after) begin
                tail_dist <= len_after;
              end
            end
            res_char   <= 8'd0;
            res_status <= ST_DONE;
            res_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/leb_checker.sv -----
// Port-level checks for the line-edit buffer, bound to the top level.
// Depends on leb_pkg and line_edit_buffer_core.
`default_nettype none

module leb_checker #(
  parameter int CAPACITY = 256
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [1:0] status,
  input wire logic [7:0] read_char,
  input wire logic [8:0] line_length,
  input wire logic [8:0] cursor_index
);
  import leb_pkg::*;

  // Reset drops any waiting result
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(read_char)))
    else $error("result changed while waiting");

  // A result that is not a success carries no character
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_DONE) |-> (read_char == 8'd0))
    else $error("character on a failed or non-read result");

  // Cursor never lies beyond the end of the line
  a_cursor: assert property (@(posedge clk) disable iff (rst)
    (!empty && CAPACITY < 512) |-> (cursor_index <= line_length))
    else $error("cursor beyond line end");

  // Status stays within its defined codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status != 2'd3))
    else $error("undefined status code");

endmodule

bind line_edit_buffer_core leb_checker #(.CAPACITY(CAPACITY)) u_leb_checker (.*);

`default_nettype wire

// ----- dv/line_edit_buffer_checker.sv -----
// Checker for the line-edit buffer: tracks each request and compares the results.
// Depends on leb_pkg; instantiated beside the block by line_edit_buffer_core_tb.

module line_edit_buffer_checker #(
  parameter int CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [2:0] command,
  input  logic [7:0] key_byte,
  input  logic [8:0] position_index,
  input  logic       empty,
  input  logic       pop,
  input  logic [1:0] status,
  input  logic [7:0] read_char,
  input  logic [8:0] line_length,
  input  logic [8:0] cursor_index,
  output int         fail_count,
  output int         outstanding
);
  import leb_pkg::*;

  typedef struct {
    status_t    st;
    logic [7:0] ch;
    logic [8:0] len;
    logic [8:0] cur;
  } edit_result_t;

  // Shadow copy of the line, its length and the cursor distance from the end
  logic [7:0]   line_text [CAPACITY];
  int           line_len;
  int           cur_dist;
  edit_result_t pending_results [$];
  edit_result_t want;
  int           mismatches = 0;

  assign fail_count = mismatches;

  // Apply one request to the shadow line and return the result it should give
  function automatic edit_result_t predict_edit(input logic [2:0] cmd, input logic [7:0] kb,
                                                input logic [8:0] pos);
    edit_result_t r;
    int           at;
    int           p;
    r.st = ST_NONE;
    r.ch = '0;
    at = line_len - cur_dist;
    p = pos;
    case (cmd)
      CMD_KEY: begin
        if (kb == KEY_BACKSPACE) begin
          // delete before the cursor, shift the tail left
          if (at != 0) begin
            for (int i = at - 1; i + 1 < line_len; i++) line_text[i] = line_text[i + 1];
            line_len--;
            r.st = ST_DONE;
          end
        end else if (kb >= KEY_PRINT_LO && kb <= KEY_PRINT_HI) begin
          // insert at the cursor, shift the tail right; refuse when full
          if (line_len >= CAPACITY) begin
            r.st = ST_BAD;
          end else begin
            for (int i = line_len; i > at; i--) line_text[i] = line_text[i - 1];
            line_text[at] = kb;
            line_len++;
            r.st = ST_DONE;
          end
        end
      end
      CMD_FWD: begin
        if (cur_dist != 0) begin
          cur_dist--;
          r.st = ST_DONE;
        end
      end
      CMD_BACK: begin
        if (cur_dist < line_len) begin
          cur_dist++;
          r.st = ST_DONE;
        end
      end
      CMD_SET: begin
        if (p > line_len) begin
          r.st = ST_BAD;
        end else begin
          cur_dist = line_len - p;
          r.st = ST_DONE;
        end
      end
      CMD_READ: begin
        if (p >= line_len) begin
          r.st = ST_BAD;
        end else begin
          r.ch = line_text[p];
          r.st = ST_DONE;
        end
      end
      CMD_DISCARD: begin
        // drop a prefix; clamp the cursor to the shorter line
        if (p > line_len) begin
          r.st = ST_BAD;
        end else begin
          for (int i = 0; i + p < line_len; i++) line_text[i] = line_text[i + p];
          line_len -= p;
          if (cur_dist > line_len) cur_dist = line_len;
          r.st = ST_DONE;
        end
      end
      CMD_WRITE: begin
        if (p >= line_len) begin
          r.st = ST_BAD;
        end else begin
          line_text[p] = kb;
          r.st = ST_DONE;
        end
      end
      default: r.st = ST_NONE;
    endcase
    r.len = 9'(line_len);
    r.cur = 9'(line_len - cur_dist);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      line_len = 0;
      cur_dist = 0;
      foreach (line_text[i]) line_text[i] = '0;
      pending_results.delete();
      outstanding <= 0;
    end else begin
      // compare a taken result with the oldest expectation
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d, line_length %0d", status, line_length);
          mismatches++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            mismatches++;
          end
          if (read_char !== want.ch) begin
            $error("read_char: expected %0h, got %0h", want.ch, read_char);
            mismatches++;
          end
          if (line_length !== want.len) begin
            $error("line_length: expected %0d, got %0d", want.len, line_length);
            mismatches++;
          end
          if (cursor_index !== want.cur) begin
            $error("cursor_index: expected %0d, got %0d", want.cur, cursor_index);
            mismatches++;
          end
        end
      end
      // predict a taken request
      if (push && !full) pending_results.push_back(predict_edit(command, key_byte,
                                                                position_index));
      outstanding <= pending_results.size();
    end
  end

endmodule

// ----- dv/line_edit_buffer_core_tb.sv -----
// Testbench top for line_edit_buffer_core: clock, reset, requests and the verdict.
// Depends on leb_pkg, line_edit_buffer_core and line_edit_buffer_checker.

module line_edit_buffer_core_tb;
  import leb_pkg::*;

  localparam int         CAPACITY     = 256;
  localparam int         DRAIN_CYCLES = CAPACITY + 16;
  localparam logic [2:0] CMD_SPARE    = 3'd7;

  logic       clk            = 1'b0;
  logic       rst            = 1'b1;
  logic       push           = 1'b0;
  logic [2:0] command        = CMD_KEY;
  logic [7:0] key_byte       = '0;
  logic [8:0] position_index = '0;
  logic       pop            = 1'b0;
  logic       full;
  logic       empty;
  logic [1:0] status;
  logic [7:0] read_char;
  logic [8:0] line_length;
  logic [8:0] cursor_index;
  int         fail_count;
  int         outstanding;
  int         send_idle = 36;
  int         recv_idle = 76;

  line_edit_buffer_core #(.CAPACITY(CAPACITY)) uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .key_byte(key_byte), .position_index(position_index), .empty(empty), .pop(pop),
    .status(status), .read_char(read_char), .line_length(line_length),
    .cursor_index(cursor_index)
  );

  line_edit_buffer_checker #(.CAPACITY(CAPACITY)) edit_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .key_byte(key_byte), .position_index(position_index), .empty(empty), .pop(pop),
    .status(status), .read_char(read_char), .line_length(line_length),
    .cursor_index(cursor_index), .fail_count(fail_count), .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  // Stall the result side at random
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Offer one request after a random gap; hold it until it is taken
  task automatic send_request(input logic [2:0] cmd, input logic [7:0] kb,
                              input logic [8:0] pos);
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push           <= 1'b1;
    command        <= cmd;
    key_byte       <= kb;
    position_index <= pos;
    do @(posedge clk); while (full);
  endtask

  // Hold off until every outstanding request has its result
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Mostly short indices, now and then anywhere in range
  function automatic logic [8:0] pick_position();
    if ($urandom_range(0, 7) == 0) return 9'($urandom_range(0, CAPACITY));
    return 9'($urandom_range(0, 48));
  endfunction

  // Typing with edits mixed in; a few stray bytes and spare codes as noise
  task automatic send_random_request();
    int         roll;
    logic [7:0] any_byte;
    roll = $urandom_range(0, 99);
    any_byte = 8'($urandom_range(0, 255));
    if (roll < 45)      send_request(CMD_KEY, 8'($urandom_range(KEY_PRINT_LO, KEY_PRINT_HI)),
                                     pick_position());
    else if (roll < 53) send_request(CMD_KEY, KEY_BACKSPACE, pick_position());
    else if (roll < 57) send_request(CMD_KEY, any_byte, pick_position());
    else if (roll < 65) send_request(CMD_FWD, any_byte, pick_position());
    else if (roll < 73) send_request(CMD_BACK, any_byte, pick_position());
    else if (roll < 79) send_request(CMD_SET, any_byte, pick_position());
    else if (roll < 87) send_request(CMD_READ, any_byte, pick_position());
    else if (roll < 92) send_request(CMD_WRITE, any_byte, pick_position());
    else if (roll < 97) send_request(CMD_DISCARD, any_byte, 9'($urandom_range(0, 8)));
    else                send_request(CMD_SPARE, any_byte, pick_position());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty line: every edit and move has nothing to act on
    send_request(CMD_KEY, KEY_BACKSPACE, 9'd0);
    send_request(CMD_KEY, 8'h1F, 9'd0);
    send_request(CMD_KEY, 8'h7F, 9'd0);
    send_request(CMD_KEY, 8'hFF, 9'd511 & 9'd255);
    send_request(CMD_FWD, 8'h00, 9'd0);
    send_request(CMD_BACK, 8'h00, 9'd0);
    send_request(CMD_READ, 8'h00, 9'd0);
    send_request(CMD_WRITE, 8'h55, 9'd0);
    send_request(CMD_SET, 8'h00, 9'd1);
    send_request(CMD_SET, 8'h00, 9'd0);
    send_request(CMD_DISCARD, 8'h00, 9'd0);
    send_request(CMD_DISCARD, 8'h00, 9'd1);
    // Type the printable extremes, then edit in the middle
    send_request(CMD_KEY, KEY_PRINT_LO, 9'd0);
    send_request(CMD_KEY, KEY_PRINT_HI, 9'd0);
    send_request(CMD_KEY, 8'h41, 9'd0);
    send_request(CMD_KEY, 8'h42, 9'd0);
    send_request(CMD_BACK, 8'h00, 9'd0);
    send_request(CMD_BACK, 8'h00, 9'd0);
    send_request(CMD_KEY, 8'h43, 9'd0);
    send_request(CMD_KEY, KEY_BACKSPACE, 9'd0);
    send_request(CMD_FWD, 8'h00, 9'd0);
    // An overwrite and read in the middle, reads at and past the end; any byte may be stored
    send_request(CMD_WRITE, 8'hFF, 9'd1);
    send_request(CMD_READ, 8'h00, 9'd1);
    send_request(CMD_READ, 8'h00, 9'd4);
    send_request(CMD_READ, 8'h00, 9'd256);
    send_request(CMD_SET, 8'h00, 9'd256);
    // Discard past the cursor, then the spare code
    send_request(CMD_SET, 8'h00, 9'd1);
    send_request(CMD_DISCARD, 8'h00, 9'd3);
    send_request(CMD_SPARE, 8'hFF, 9'd256);

    repeat (90) send_random_request();

    send_idle = 76;
    recv_idle = 36;
    repeat (90) send_random_request();

    // Fill the line from idle, then work at the top of the store
    wait_drained();
    send_idle = 0;
    recv_idle = 0;
    repeat (CAPACITY + 4) send_request(CMD_KEY,
                                       8'($urandom_range(KEY_PRINT_LO, KEY_PRINT_HI)), 9'd0);
    send_request(CMD_READ, 8'h00, 9'd255);
    send_request(CMD_WRITE, 8'h00, 9'd255);
    send_request(CMD_READ, 8'h00, 9'd255);
    send_request(CMD_READ, 8'h00, 9'd256);
    send_request(CMD_SET, 8'h00, 9'd256);
    send_request(CMD_SET, 8'h00, 9'd0);
    send_request(CMD_KEY, 8'h5A, 9'd0);
    send_request(CMD_KEY, KEY_BACKSPACE, 9'd0);
    send_request(CMD_FWD, 8'h00, 9'd0);
    send_request(CMD_KEY, KEY_BACKSPACE, 9'd0);
    send_request(CMD_KEY, 8'h5A, 9'd0);
    send_request(CMD_DISCARD, 8'h00, 9'd200);
    repeat (90) send_random_request();

    // Drain and let any stray result show up
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("line_edit_buffer_core_tb passed");
    end else begin
      $display("line_edit_buffer_core_tb failed");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #10_000_000;
    $display("line_edit_buffer_core_tb failed");
    $finish;
  end

endmodule
